[rtl/ktc_pkg.sv]
`default_nettype none

package ktc_pkg;

   // keyword table
   localparam int KW_NUM = 8;
   localparam int WORD_LEN_W = 4;

   // keyword text stored reversed, so character p sits at bits [8p +: 8]
   localparam logic [63:0] KW_TEXT [KW_NUM] = '{
      64'("edulcni"), 64'("tni"), 64'("taolf"), 64'("rahc"),
      64'("elbuod"), 64'("otog"), 64'("rof"), 64'("elihw")
   };

   localparam logic [WORD_LEN_W-1:0] KW_LEN [KW_NUM] = '{
      4'd7, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4, 4'd3, 4'd5
   };

   localparam logic [WORD_LEN_W-1:0] WORD_LEN_MAX = 4'd15;

   // class of the word closed by an item
   typedef enum logic [1:0] {
      WC_NONE    = 2'd0,
      WC_KEYWORD = 2'd1,
      WC_IDENT   = 2'd2,
      WC_INVALID = 2'd3
   } word_class_type;

   // class of the byte itself
   typedef enum logic [2:0] {
      DC_WORD    = 3'd0,
      DC_SPACE   = 3'd1,
      DC_OPER    = 3'd2,
      DC_PUNCT   = 3'd3,
      DC_IGNORED = 3'd4
   } delim_class_type;

   // word in progress
   typedef struct packed {
      logic [KW_NUM-1:0]     cand;
      logic [WORD_LEN_W-1:0] len;
      logic                  first_letter;
   } word_state_type;

   // outcome of scanning one byte
   typedef struct packed {
      word_state_type  word_next;
      word_class_type  word_class;
      delim_class_type delim_class;
      logic            kw_inc;
      logic            id_inc;
      logic            op_inc;
      logic            pu_inc;
      logic            set_halt;
   } scan_result_type;

endpackage

`default_nettype wire

[rtl/ktc_scan.sv]
`default_nettype none

module ktc_scan (
   input  wire logic [7:0]               byte_value,
   input  wire ktc_pkg::word_state_type  word_cur,
   input  wire logic                     halted,
   output ktc_pkg::scan_result_type      result
);
   import ktc_pkg::*;

   // classify the byte, advance the candidate mask, close words on delimiters
   always_comb begin
      logic              is_letter;
      logic              is_digit;
      logic [KW_NUM-1:0] mask;
      logic              kw_hit;

      is_letter = (byte_value inside {[8'h41:8'h5a], [8'h61:8'h7a]});
      is_digit  = (byte_value inside {[8'h30:8'h39]});
      mask      = '0;
      kw_hit    = 1'b0;

      result             = '0;
      result.word_next   = word_cur;
      result.word_class  = WC_NONE;
      result.delim_class = DC_IGNORED;

      if (!halted) begin
         if (byte_value inside {8'h2c, 8'h3b}) begin
            result.delim_class = DC_PUNCT;
         end else if (byte_value inside {8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h25, 8'h3d}) begin
            result.delim_class = DC_OPER;
         end else if (byte_value inside {8'h20, [8'h09:8'h0d]}) begin
            result.delim_class = DC_SPACE;
         end else if (is_letter || is_digit || byte_value == 8'h5f) begin
            result.delim_class = DC_WORD;
         end

         // per-keyword prefix match and hit on exact length
         for (int k = 0; k < KW_NUM; k++) begin
            if (word_cur.cand[k] && (word_cur.len < KW_LEN[k]) &&
                (KW_TEXT[k][{word_cur.len[2:0], 3'b000} +: 8] == byte_value)) begin
               mask[k] = 1'b1;
            end
            if (word_cur.cand[k] && (KW_LEN[k] == word_cur.len)) begin
               kw_hit = 1'b1;
            end
         end

         case (result.delim_class)
            DC_WORD: begin
               result.word_next.cand = mask;
               if (word_cur.len == '0) begin
                  result.word_next.first_letter = is_letter;
               end
               if (word_cur.len != WORD_LEN_MAX) begin
                  result.word_next.len = word_cur.len + 1'b1;
               end
            end
            DC_SPACE, DC_OPER, DC_PUNCT: begin
               result.pu_inc = (result.delim_class == DC_PUNCT);
               result.op_inc = (result.delim_class == DC_OPER);
               if (word_cur.len != '0) begin
                  if (kw_hit) begin
                     result.word_class = WC_KEYWORD;
                     result.kw_inc     = 1'b1;
                  end else if (word_cur.first_letter) begin
                     result.word_class = WC_IDENT;
                     result.id_inc     = 1'b1;
                  end else begin
                     result.word_class = WC_INVALID;
                     result.set_halt   = 1'b1;
                  end
               end
               result.word_next.cand         = '1;
               result.word_next.len          = '0;
               result.word_next.first_letter = 1'b0;
            end
            default: begin
               result.word_next = word_cur;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/keyword_token_classifier_unit.sv]
`default_nettype none

// an accepted item is held in the input register and loads the result register when that
// register is free, or waits there while a waiting result is stalled by rsp_ready
// one item per cycle while rsp_ready does not stall the result; each byte goes through one registered scan pass,
// and the word state and counters update as the item moves into the result register
// reset clears the input and result stages, the word state, all counters and
// the halted flag

module keyword_token_classifier_unit #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic [7:0]  req_byte_value,
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic [1:0]        rsp_word_class,
   output logic [2:0]        rsp_delimiter_class,
   output logic [15:0]       rsp_keyword_total,
   output logic [15:0]       rsp_identifier_total,
   output logic [15:0]       rsp_operator_total,
   output logic [15:0]       rsp_punctuator_total,
   output logic              rsp_halted
);
   import ktc_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   word_class_type         word_class_ff;
   delim_class_type        delim_class_ff;
   word_state_type         word_ff, word_in;
   logic                   halt_ff, halt_in;
   logic [COUNT_WIDTH-1:0] kw_cnt_ff, kw_cnt_in;
   logic [COUNT_WIDTH-1:0] id_cnt_ff, id_cnt_in;
   logic [COUNT_WIDTH-1:0] op_cnt_ff, op_cnt_in;
   logic [COUNT_WIDTH-1:0] pu_cnt_ff, pu_cnt_in;
   logic                   load_out;
   scan_result_type        scan;

   // stage handshake
   assign load_out  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || load_out;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (load_out) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   ktc_scan u_scan (
      .byte_value (in_byte_ff),
      .word_cur   (word_ff),
      .halted     (halt_ff),
      .result     (scan)
   );

   // next state and saturating counters
   always_comb begin
      word_in   = word_ff;
      halt_in   = halt_ff;
      kw_cnt_in = kw_cnt_ff;
      id_cnt_in = id_cnt_ff;
      op_cnt_in = op_cnt_ff;
      pu_cnt_in = pu_cnt_ff;
      if (load_out) begin
         word_in = scan.word_next;
         halt_in = halt_ff || scan.set_halt;
         if (scan.kw_inc && kw_cnt_ff != '1) kw_cnt_in = kw_cnt_ff + 1'b1;
         if (scan.id_inc && id_cnt_ff != '1) id_cnt_in = id_cnt_ff + 1'b1;
         if (scan.op_inc && op_cnt_ff != '1) op_cnt_in = op_cnt_ff + 1'b1;
         if (scan.pu_inc && pu_cnt_ff != '1) pu_cnt_in = pu_cnt_ff + 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         word_ff      <= '{cand: '1, len: '0, first_letter: 1'b0};
         halt_ff      <= 1'b0;
         kw_cnt_ff    <= '0;
         id_cnt_ff    <= '0;
         op_cnt_ff    <= '0;
         pu_cnt_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         word_ff      <= word_in;
         halt_ff      <= halt_in;
         kw_cnt_ff    <= kw_cnt_in;
         id_cnt_ff    <= id_cnt_in;
         op_cnt_ff    <= op_cnt_in;
         pu_cnt_ff    <= pu_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_value;
      end
      if (load_out) begin
         word_class_ff  <= scan.word_class;
         delim_class_ff <= scan.delim_class;
      end
   end

   // result ports; counters and flag change only when a new result loads
   assign rsp_valid            = out_valid_ff;
   assign rsp_word_class       = word_class_ff;
   assign rsp_delimiter_class  = delim_class_ff;
   assign rsp_keyword_total    = 16'(kw_cnt_ff);
   assign rsp_identifier_total = 16'(id_cnt_ff);
   assign rsp_operator_total   = 16'(op_cnt_ff);
   assign rsp_punctuator_total = 16'(pu_cnt_ff);
   assign rsp_halted           = halt_ff;

   // halted flag is sticky until reset
   assert property (@(posedge clock) disable iff (reset) halt_ff |=> halt_ff)
      else $error("halted flag cleared without reset");

   // an invalid word always reports halted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word_class == WC_INVALID) |-> rsp_halted)
      else $error("invalid word without halted");

   // while halted no counter moves
   assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> ($stable(kw_cnt_ff) && $stable(id_cnt_ff) &&
                   $stable(op_cnt_ff) && $stable(pu_cnt_ff)))
      else $error("counter changed while halted");

   // state only advances when a result loads
   assert property (@(posedge clock) disable iff (reset)
      !load_out |=> ($stable(word_ff) && $stable(kw_cnt_ff)))
      else $error("word state changed without a result load");

endmodule

`default_nettype wire
